/* hw/rtl/pidb_pkg.sv */
// ----------------------------------------------------------------------------
// pidb_pkg
// Shared types, codes and helpers for the pooled ID bitmap allocator.
// ----------------------------------------------------------------------------
package pidb_pkg;

    localparam int MAP_W  = 64;   // bits in one used-bitmap word
    localparam int ID_W   = 6;    // width of an ID
    localparam int POOL_W = 2;    // width of the pool selector
    localparam int DEV_W  = 3;    // width of the device field

    typedef logic [2:0]        status_t;
    typedef logic [MAP_W-1:0]  map_word_t;

    // Result codes
    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_BAD_DEVICE = 3'd1;
    localparam status_t ST_FULL       = 3'd2;
    localparam status_t ST_TASK_FULL  = 3'd3;
    localparam status_t ST_BAD_VALUE  = 3'd4;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Pools
    localparam logic [POOL_W-1:0] POOL_STREAM     = 2'd0;
    localparam logic [POOL_W-1:0] POOL_EVENT      = 2'd1;
    localparam logic [POOL_W-1:0] POOL_TASK       = 2'd2;
    localparam logic [POOL_W-1:0] POOL_QUEUE_PAIR = 2'd3;

    // Read/write strobes toward the bitmap store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } map_cmd_t;

    // Result of a lowest-set-bit search
    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] idx;
    } first_hit_t;

    // Mask with the low n bits set
    function automatic map_word_t id_mask(input int n);
        map_word_t m;
        m = '0;
        for (int i = 0; i < MAP_W; i++) begin
            if (i < n) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    // Lowest set bit of a word
    function automatic first_hit_t find_first(input map_word_t vec);
        first_hit_t r;
        r = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (vec[i]) begin
                r.found = 1'b1;
                r.idx   = ID_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/pidb_map_store.sv */
// ----------------------------------------------------------------------------
// pidb_map_store
// Bitmap memory: one write port, one registered read port, per-entry valid
// bits so that entries never written read as all zero after reset.
// ----------------------------------------------------------------------------
module pidb_map_store #(
    parameter int AW = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pidb_pkg::map_cmd_t  cmd,
    input  logic [AW-1:0]       rd_addr,
    input  logic [AW-1:0]       wr_addr,
    input  pidb_pkg::map_word_t wr_data,
    output pidb_pkg::map_word_t rd_data
);
    import pidb_pkg::*;

    localparam int DEPTH = 1 << AW;

    map_word_t         mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    map_word_t         rd_data_reg;
    logic              rd_valid_reg;

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Mark written entries; hold the valid flag of the last read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/pooled_id_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// pooled_id_bitmap_allocator
// Hands out and takes back small IDs from four per-device pools.
// ----------------------------------------------------------------------------
// For each request word, the accept cycle reads the chosen device's
// used-bitmap from a single synchronous memory, and in the update state the
// block searches and updates that word and writes it back while loading the
// result register. A new request is taken only once that update is done; a
// stalled result holds the block in its update state until the result
// register frees up. The store holds one 64-bit word per (pool, device) pair;
// per-entry valid bits make every bitmap read as empty right after reset,
// so no clearing pass is needed. An allocate returns the lowest free ID of
// the pool; a full pool reports a pool-full code (a distinct one for the
// task pool), and a device at or above NUM_DEVICES reports an invalid
// device. A free checks device, ID range and that the ID is in use, and
// reports an invalid value otherwise.
// ----------------------------------------------------------------------------
module pooled_id_bitmap_allocator #(
    parameter int NUM_DEVICES    = 8,
    parameter int STREAM_IDS     = 64,
    parameter int EVENT_IDS      = 64,
    parameter int TASK_IDS       = 64,
    parameter int QUEUE_PAIR_IDS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [pidb_pkg::POOL_W-1:0]   pool,
    input  logic [pidb_pkg::DEV_W-1:0]    device,
    input  logic [pidb_pkg::ID_W-1:0]     slot_id,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output pidb_pkg::status_t             status,
    output logic [pidb_pkg::ID_W-1:0]     granted_id
);
    import pidb_pkg::*;

    // Address = {pool, device index}
    localparam int DEV_AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int AW     = POOL_W + DEV_AW;

    // Valid-ID masks of each pool
    localparam map_word_t STREAM_MASK     = id_mask(STREAM_IDS);
    localparam map_word_t EVENT_MASK      = id_mask(EVENT_IDS);
    localparam map_word_t TASK_MASK       = id_mask(TASK_IDS);
    localparam map_word_t QUEUE_PAIR_MASK = id_mask(QUEUE_PAIR_IDS);

    typedef enum logic {
        S_IDLE,
        S_MODIFY
    } state_t;

    state_t              state_reg;
    logic                cmd_reg;
    logic [POOL_W-1:0]   pool_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic [ID_W-1:0]     id_reg;
    logic                out_valid_reg;
    status_t             status_reg;
    logic [ID_W-1:0]     granted_reg;

    logic                accept;
    logic                fire;
    map_cmd_t            map_cmd;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    map_word_t           rd_word;
    map_word_t           wr_word;
    map_word_t           size_mask;
    first_hit_t          hit;
    logic                dev_ok;
    logic                do_write;
    status_t             status_next;
    logic [ID_W-1:0]     granted_next;

    // Take a request only when no word is being worked on
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Finish the update once the result register is free or being drained
    assign fire = (state_reg == S_MODIFY) && (!out_valid_reg || !out_stall);

    assign rd_addr = {pool, DEV_AW'(device)};
    assign wr_addr = {pool_reg, DEV_AW'(dev_reg)};

    // ------------------------------------------------------------------
    // Search and update of the word read in the accept cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        case (pool_reg)
            POOL_STREAM:     size_mask = STREAM_MASK;
            POOL_EVENT:      size_mask = EVENT_MASK;
            POOL_TASK:       size_mask = TASK_MASK;
            POOL_QUEUE_PAIR: size_mask = QUEUE_PAIR_MASK;
            default:         size_mask = '0;
        endcase
    end

    assign dev_ok = (int'(dev_reg) < NUM_DEVICES);
    assign hit    = find_first(~rd_word & size_mask);

    always_comb
    begin
        do_write     = 1'b0;
        wr_word      = rd_word;
        status_next  = ST_OK;
        granted_next = '0;
        if (cmd_reg == CMD_ALLOC)
        begin
            if (!dev_ok)
            begin
                status_next = ST_BAD_DEVICE;
            end
            else if (hit.found)
            begin
                // claim the lowest free ID
                do_write        = 1'b1;
                wr_word[hit.idx] = 1'b1;
                granted_next    = hit.idx;
            end
            else
            begin
                // the task pool reports running out of memory
                status_next = (pool_reg == POOL_TASK) ? ST_TASK_FULL : ST_FULL;
            end
        end
        else
        begin
            // release only an in-range ID that is marked used
            if (dev_ok && size_mask[id_reg] && rd_word[id_reg])
            begin
                do_write        = 1'b1;
                wr_word[id_reg] = 1'b0;
            end
            else
            begin
                status_next = ST_BAD_VALUE;
            end
        end
    end

    assign map_cmd.rd_en = accept;
    assign map_cmd.wr_en = fire && do_write;

    pidb_map_store #(
        .AW (AW)
    ) u_map_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (map_cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_data (rd_word)
    );

    // ------------------------------------------------------------------
    // Request capture
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            pool_reg <= pool;
            dev_reg  <= device;
            id_reg   <= slot_id;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            granted_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_MODIFY;
                    end
                end
                S_MODIFY:
                begin
                    if (fire)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
                granted_reg   <= granted_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign granted_id = granted_reg;

endmodule

/* hw/rtl/pidb_checker.sv */
// ----------------------------------------------------------------------------
// pidb_checker
// Port-level checks of the pooled ID bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pidb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input pidb_pkg::status_t           status,
    input logic [pidb_pkg::ID_W-1:0]   granted_id
);
    import pidb_pkg::*;

    // A held result keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_id))
    else $error("result changed while stalled");

    // Only a granted allocate carries an ID
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> granted_id == '0)
    else $error("nonzero ID with error status");

    // Status is always a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_BAD_DEVICE) ||
                      (status == ST_FULL) || (status == ST_TASK_FULL) ||
                      (status == ST_BAD_VALUE))
    else $error("undefined status code");

    // The cycle after an accept is spent on the update
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("request taken during update");

endmodule

bind pooled_id_bitmap_allocator pidb_checker u_pidb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .granted_id (granted_id)
);

/* test/pidb_grant_checker.sv */
// ----------------------------------------------------------------------------
// pidb_grant_checker
// Watches both channels of the ID allocator, keeps its own copy of the
// per-device used maps, predicts each grant and compares it with the result.
// ----------------------------------------------------------------------------
module pidb_grant_checker #(
    parameter int NUM_DEVICES    = 8,
    parameter int STREAM_IDS     = 64,
    parameter int EVENT_IDS      = 64,
    parameter int TASK_IDS       = 64,
    parameter int QUEUE_PAIR_IDS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        command,
    input  logic [pidb_pkg::POOL_W-1:0] pool,
    input  logic [pidb_pkg::DEV_W-1:0]  device,
    input  logic [pidb_pkg::ID_W-1:0]   slot_id,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  pidb_pkg::status_t           status,
    input  logic [pidb_pkg::ID_W-1:0]   granted_id,
    output int                          errors,
    output int                          pending,
    output int                          results_seen,
    output int                          fulls_seen,
    output int                          rejects_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    import pidb_pkg::*;

    typedef struct packed {
        status_t         code;
        logic [ID_W-1:0] grant;
    } grant_result_t;

    map_word_t     used_map [4][NUM_DEVICES];
    grant_result_t grants_due[$];
    grant_result_t want;

    function automatic int pool_ids(input logic [POOL_W-1:0] pl);
        case (pl)
            POOL_STREAM: return STREAM_IDS;
            POOL_EVENT:  return EVENT_IDS;
            POOL_TASK:   return TASK_IDS;
            default:     return QUEUE_PAIR_IDS;
        endcase
    endfunction

    // Apply one request to the shadow maps and return the result it must give.
    function automatic grant_result_t predict_grant(input logic cmd,
                                                    input logic [POOL_W-1:0] pl,
                                                    input logic [DEV_W-1:0] dev,
                                                    input logic [ID_W-1:0] id);
        grant_result_t r;
        int            limit;
        bit            hit;
        r.code  = ST_OK;
        r.grant = '0;
        limit   = pool_ids(pl);
        hit     = 1'b0;
        if (cmd == CMD_ALLOC) begin
            if (dev >= NUM_DEVICES) begin
                r.code = ST_BAD_DEVICE;
            end else begin
                for (int i = 0; i < limit && i < MAP_W; i++) begin
                    if (!hit && !used_map[pl][dev][i]) begin
                        hit     = 1'b1;
                        r.grant = ID_W'(i);
                    end
                end
                if (hit) begin
                    used_map[pl][dev][r.grant] = 1'b1;
                end else begin
                    r.code = (pl == POOL_TASK) ? ST_TASK_FULL : ST_FULL;
                end
            end
        end else if (dev >= NUM_DEVICES || id >= limit || !used_map[pl][dev][id]) begin
            r.code = ST_BAD_VALUE;
        end else begin
            used_map[pl][dev][id] = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (used_map[p, d]) begin
                used_map[p][d] = '0;
            end
            grants_due.delete();
            errors       = 0;
            pending      = 0;
            results_seen = 0;
            fulls_seen   = 0;
            rejects_seen = 0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (status == ST_FULL || status == ST_TASK_FULL) begin
                    fulls_seen++;
                end
                if (status == ST_BAD_VALUE) begin
                    rejects_seen++;
                end
                if (grants_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got status %0d id %0d",
                             $time, status, granted_id);
                end else begin
                    want = grants_due.pop_front();
                    if (status !== want.code) begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.code, status);
                    end
                    if (granted_id !== want.grant) begin
                        errors++;
                        $display("%0t: granted_id mismatch, expected %0d, got %0d",
                                 $time, want.grant, granted_id);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                grants_due.push_back(predict_grant(command, pool, device, slot_id));
            end
            pending = grants_due.size();
        end
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Top-level test of the pooled ID bitmap allocator: drives allocate and free
// words in three flow-control phases, fills pools to overflow and releases
// some of their IDs, and leaves prediction and comparison to the grant checker.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pidb_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_WORDS  = 400;
    localparam int DRAIN_CYCLES = 20;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              command    = CMD_ALLOC;
    logic [POOL_W-1:0] pool       = POOL_STREAM;
    logic [DEV_W-1:0]  device     = '0;
    logic [ID_W-1:0]   slot_id    = '0;
    logic              out_stall  = 1'b0;
    logic              in_stall;
    logic              out_valid;
    status_t           status;
    logic [ID_W-1:0]   granted_id;

    int errors;
    int pending;
    int results_seen;
    int fulls_seen;
    int rejects_seen;

    // Idle percentages for the current phase, sender and receiver side
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int words_sent = 0;
    int fills_done = 0;
    int cycle_count = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pooled_id_bitmap_allocator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .pool       (pool),
        .device     (device),
        .slot_id    (slot_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .granted_id (granted_id)
    );

    pidb_grant_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .pool         (pool),
        .device       (device),
        .slot_id      (slot_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .granted_id   (granted_id),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .fulls_seen   (fulls_seen),
        .rejects_seen (rejects_seen)
    );

    // Receiver: stall at random, at the rate the current phase sets
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run and report errors if the test has not finished in time
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Send one request word and hold it until the block takes it. An idle
    // gap, when drawn, drops valid across whole clock periods first,
    // so valid is never lowered and raised in the same step.
    task automatic send_word(input logic cmd, input logic [POOL_W-1:0] pl,
                             input logic [DEV_W-1:0] dev, input logic [ID_W-1:0] id);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do begin
                @(posedge clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        pool     <= pl;
        device   <= dev;
        slot_id  <= id;
        // Sample stall away from the edge; the word goes in at the next edge
        @(negedge clk);
        while (in_stall) begin
            @(negedge clk);
        end
        @(posedge clk);
        words_sent++;
    endtask

    task automatic alloc_id(input logic [POOL_W-1:0] pl, input logic [DEV_W-1:0] dev);
        // slot_id means nothing on allocate; randomize it anyway
        send_word(CMD_ALLOC, pl, dev, ID_W'($urandom_range(63)));
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (pending != 0);
        @(posedge clk);
    endtask

    // One well-formed burst: either fill a pool past its end and then release
    // part of it, or a short mix of allocates and frees, mostly on one pool/device.
    task automatic random_episode();
        logic [POOL_W-1:0] pl;
        logic [DEV_W-1:0]  dev;
        int                n;
        int                pick;
        dev = DEV_W'($urandom_range(7));
        pl  = POOL_W'($urandom_range(3));
        if (fills_done < 4 || $urandom_range(19) == 0) begin
            // Walk every pool through full at least once early in the run
            if (fills_done < 4) begin
                pl = POOL_W'(fills_done);
            end
            fills_done++;
            repeat (66) begin
                alloc_id(pl, dev);
            end
            n = $urandom_range(10, 40);
            repeat (n) begin
                send_word(CMD_FREE, pl, dev, ID_W'($urandom_range(63)));
            end
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    alloc_id(pl, dev);
                end else if (pick < 90) begin
                    // Low IDs are handed out first, so these mostly hit used slots
                    send_word(CMD_FREE, pl, dev, ID_W'($urandom_range(15)));
                end else begin
                    // Noise: any pool, device and ID
                    send_word(CMD_FREE, POOL_W'($urandom_range(3)),
                              DEV_W'($urandom_range(7)), ID_W'($urandom_range(63)));
                end
            end
        end
    endtask

    task automatic random_words(input int quota);
        int start;
        start = words_sent;
        while (words_sent - start < quota) begin
            random_episode();
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender mostly busy, receiver stalls a lot
        send_idle_pct  = 10;
        recv_stall_pct = 80;

        // Directed: first grant per pool on devices 0, 7, 3 and 5, reuse of the
        // lowest freed ID, double free, free of an ID never handed out
        alloc_id(POOL_STREAM, 3'd0);
        alloc_id(POOL_EVENT, 3'd7);
        alloc_id(POOL_TASK, 3'd3);
        alloc_id(POOL_QUEUE_PAIR, 3'd5);
        alloc_id(POOL_STREAM, 3'd0);
        send_word(CMD_FREE, POOL_STREAM, 3'd0, 6'd0);
        send_word(CMD_FREE, POOL_STREAM, 3'd0, 6'd0);
        alloc_id(POOL_STREAM, 3'd0);
        send_word(CMD_FREE, POOL_STREAM, 3'd0, 6'd63);
        send_word(CMD_FREE, POOL_QUEUE_PAIR, 3'd5, 6'd42);
        send_word(CMD_FREE, POOL_TASK, 3'd3, 6'd0);
        send_word(CMD_FREE, POOL_EVENT, 3'd7, 6'd0);
        send_word(CMD_FREE, POOL_STREAM, 3'd0, 6'd1);
        send_word(CMD_FREE, POOL_STREAM, 3'd0, 6'd0);
        send_word(CMD_FREE, POOL_QUEUE_PAIR, 3'd5, 6'd0);
        alloc_id(POOL_EVENT, 3'd7);

        random_words(PHASE_WORDS / 2);
        drain_results();
        random_words(PHASE_WORDS / 2);

        // Phase two: sender idles a lot, receiver rarely stalls
        send_idle_pct  = 80;
        recv_stall_pct = 10;
        random_words(PHASE_WORDS);

        // Phase three: full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_words(PHASE_WORDS);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d allocate/free words over three flow-control phases, %0d pool fills.",
                 words_sent, fills_done);
        $display("Checked %0d results: %0d pool-full, %0d rejected frees.",
                 results_seen, fulls_seen, rejects_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
